// ----- hdl/dmdf_pkg.sv -----
// Shared constants for the directional mass-damper force core.
`timescale 1ns / 1ps
package dmdf_pkg;
  localparam int COEF_W      = 16;
  localparam int MAXF_W      = 23;
  localparam int DIR_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_SHIFT  = 8;
  localparam int DEF_SAMPLE_W = 18;
  localparam int DEF_FORCE_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MASS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DIR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ON = 3'd6;

  localparam logic [DIR_W-1:0] DIR_POS = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NEG = 2'd2;

  localparam logic [MAXF_W-1:0] MAXF_RESET = '1;
endpackage

// ----- hdl/dmdf_front.sv -----
// Front end: accepts a sample word, forms the four scaled products.
`timescale 1ns / 1ps
module dmdf_front import dmdf_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] vel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] vel_y,
  input  logic signed [COEF_W-1:0]       mass_x,
  input  logic signed [COEF_W-1:0]       mass_y,
  input  logic signed [COEF_W-1:0]       drag_x,
  input  logic signed [COEF_W-1:0]       drag_y,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [4*(SAMPLE_WIDTH+COEF_W+1-FRAC_SHIFT)-1:0] q_data
);
  localparam int PW = SAMPLE_WIDTH + COEF_W;
  localparam int IW = PW + 1 - FRAC_SHIFT;

  logic                 p_valid;
  logic signed [PW-1:0] pax, pay, pvx, pvy;
  logic                 accept;

  // negate then floor-shift: keep the upper bits of the negated product
  function automatic logic [IW-1:0] neg_scale(input logic signed [PW-1:0] p);
    logic signed [PW:0] n;
    n = -$signed({p[PW-1], p});
    return n[PW:FRAC_SHIFT];
  endfunction

  assign in_stall = p_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = p_valid && !q_full;
  assign q_data   = {neg_scale(pax), neg_scale(pay), neg_scale(pvx), neg_scale(pvy)};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (q_push) begin
      p_valid <= 1'b0;
    end
    if (accept) begin
      pax <= accel_x * mass_x;
      pay <= accel_y * mass_y;
      pvx <= vel_x * drag_x;
      pvy <= vel_y * drag_y;
    end
  end
endmodule

// ----- hdl/dmdf_queue.sv -----
// Two-entry queue between the front end and the limiter.
`timescale 1ns / 1ps
module dmdf_queue import dmdf_pkg::*; #(
  parameter int WIDTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
    if (push) mem[wr_ptr] <= wr_data;
  end
endmodule

// ----- hdl/dmdf_back.sv -----
// Back end: magnitude limit (root and divide), drag add, saturation, output register.
`timescale 1ns / 1ps
module dmdf_back import dmdf_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W,
  parameter int FORCE_WIDTH  = DEF_FORCE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [4*(SAMPLE_WIDTH+COEF_W+1-FRAC_SHIFT)-1:0] q_data,
  input  logic [MAXF_W-1:0]             max_force,
  input  logic [DIR_W-1:0]              pulse_dir,
  input  logic                          effect_on,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FORCE_WIDTH-1:0] force_x,
  output logic signed [FORCE_WIDTH-1:0] force_y
);
  localparam int IW = SAMPLE_WIDTH + COEF_W + 1 - FRAC_SHIFT;
  localparam int XW = ((IW > FORCE_WIDTH) ? IW : FORCE_WIDTH) + 2;
  localparam logic signed [XW-1:0] F_HI = XW'((64'sd1 <<< (FORCE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] F_LO = -F_HI - XW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ1, S_SQ2, S_TEST, S_HALVE, S_ROOT, S_MUL, S_DIV
  } state_t;

  state_t                state;
  logic                  fin;
  logic                  scaling;
  logic signed [IW-1:0]  ix, iy, dx, dy;
  logic [IW-1:0]         mx, my;
  logic                  gt;
  logic [2*IW-1:0]       acc;
  logic [2*MAXF_W-1:0]   lim2;
  logic [63:0]           rad;
  logic [34:0]           rem;
  logic [31:0]           root;
  logic [53:0]           nx, ny;
  logic [31:0]           drx, dry;
  logic [5:0]            cnt;

  logic [34:0]           rem_t, trial;
  logic [32:0]           tx, ty;
  logic signed [XW-1:0]  ex, ey, sx, sy;
  logic signed [FORCE_WIDTH-1:0] rx, ry;
  logic                  load;

  assign q_pop = (state == S_IDLE) && !fin && !q_empty;
  assign load  = fin && (!out_valid || !out_stall);

  always_comb begin
    rem_t = {rem[32:0], rad[63:62]};
    trial = {1'b0, root, 2'b01};
    tx    = {drx, nx[53]};
    ty    = {dry, ny[53]};
    if (scaling) begin
      ex = ix[IW-1] ? -$signed(XW'(nx[MAXF_W-1:0])) : $signed(XW'(nx[MAXF_W-1:0]));
      ey = iy[IW-1] ? -$signed(XW'(ny[MAXF_W-1:0])) : $signed(XW'(ny[MAXF_W-1:0]));
    end else begin
      ex = XW'(ix);
      ey = XW'(iy);
    end
    sx = ex + XW'(dx);
    sy = ey + XW'(dy);
    if (sx > F_HI)      rx = F_HI[FORCE_WIDTH-1:0];
    else if (sx < F_LO) rx = F_LO[FORCE_WIDTH-1:0];
    else                rx = sx[FORCE_WIDTH-1:0];
    if (sy > F_HI)      ry = F_HI[FORCE_WIDTH-1:0];
    else if (sy < F_LO) ry = F_LO[FORCE_WIDTH-1:0];
    else                ry = sy[FORCE_WIDTH-1:0];
    // perturbation blanks x when its sign opposes the chosen direction
    if (pulse_dir == DIR_POS && rx[FORCE_WIDTH-1]) rx = '0;
    else if (pulse_dir == DIR_NEG && !rx[FORCE_WIDTH-1] && rx != '0) rx = '0;
    if (!effect_on) begin
      rx = '0;
      ry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        fin       <= 1'b0;
      end else if (out_stall == 1'b0) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) state <= S_SQ1;
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          state <= scaling ? S_ROOT : S_TEST;
        end
        S_TEST: begin
          if (gt || 64'(acc) > 64'(lim2)) begin
            state <= S_HALVE;
          end else begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
        end
        S_HALVE: begin
          if (!(64'(mx) >= 64'h8000_0000 || 64'(my) >= 64'h8000_0000)) state <= S_SQ1;
        end
        S_ROOT: begin
          if (cnt == 6'd0) state <= S_MUL;
        end
        S_MUL: begin
          if (root == 32'd0) begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    // datapath
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          ix      <= q_data[4*IW-1:3*IW];
          iy      <= q_data[3*IW-1:2*IW];
          dx      <= q_data[2*IW-1:IW];
          dy      <= q_data[IW-1:0];
          mx      <= q_data[4*IW-1] ? IW'(-$signed(q_data[4*IW-1:3*IW]))
                                    : q_data[4*IW-1:3*IW];
          my      <= q_data[3*IW-1] ? IW'(-$signed(q_data[3*IW-1:2*IW]))
                                    : q_data[3*IW-1:2*IW];
          scaling <= 1'b0;
        end
      end
      S_SQ1: begin
        acc  <= mx * mx;
        lim2 <= max_force * max_force;
        gt   <= (mx > IW'(max_force)) || (my > IW'(max_force)) ||
                (64'(mx) > 64'(max_force)) || (64'(my) > 64'(max_force));
      end
      S_SQ2: begin
        acc <= acc + my * my;
        rad <= 64'(acc + my * my);
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd31;
      end
      S_TEST: ;
      S_HALVE: begin
        if (64'(mx) >= 64'h8000_0000 || 64'(my) >= 64'h8000_0000) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end else begin
          scaling <= 1'b1;
        end
      end
      S_ROOT: begin
        rad <= rad << 2;
        cnt <= cnt - 6'd1;
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[30:0], 1'b0};
        end
      end
      S_MUL: begin
        nx  <= 54'(31'(mx)) * 54'(max_force);
        ny  <= 54'(31'(my)) * 54'(max_force);
        drx <= '0;
        dry <= '0;
        cnt <= 6'd53;
        if (root == 32'd0) begin
          nx <= '0;
          ny <= '0;
        end
      end
      S_DIV: begin
        cnt <= cnt - 6'd1;
        if (tx >= {1'b0, root}) begin
          drx <= 32'(tx - {1'b0, root});
          nx  <= {nx[52:0], 1'b1};
        end else begin
          drx <= tx[31:0];
          nx  <= {nx[52:0], 1'b0};
        end
        if (ty >= {1'b0, root}) begin
          dry <= 32'(ty - {1'b0, root});
          ny  <= {ny[52:0], 1'b1};
        end else begin
          dry <= ty[31:0];
          ny  <= {ny[52:0], 1'b0};
        end
      end
      default: ;
    endcase

    if (load) begin
      force_x <= rx;
      force_y <= ry;
    end
  end
endmodule

// ----- hdl/directional_mass_damper_force_core.sv -----
// Top level of the directional mass-damper force core.
`timescale 1ns / 1ps
// Each sample word (acceleration and velocity, x and y) yields one force word. The front end
// takes a word every cycle, unless in_stall holds it, into its product register and a two-entry
// queue; in the back end a sample whose inertial force is within max_force only takes the
// squaring and the limit test, while one whose force must be rescaled (after halving steps for
// very wide samples) takes a 32-step square root, then two 54-step restoring divisions side by
// side, one bit a cycle. The back end's result sits in an output register, so the next word is
// worked on while a finished one waits. Config writes are always taken (cfg_ready is tied high)
// and must land while the core is idle.
module directional_mass_damper_force_core import dmdf_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W,
  parameter int FORCE_WIDTH  = DEF_FORCE_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] vel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] vel_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [FORCE_WIDTH-1:0]  force_x,
  output logic signed [FORCE_WIDTH-1:0]  force_y
);
  localparam int IW = SAMPLE_WIDTH + COEF_W + 1 - FRAC_SHIFT;

  logic signed [COEF_W-1:0] mass_x, mass_y, drag_x, drag_y;
  logic [MAXF_W-1:0]        max_force;
  logic [DIR_W-1:0]         pulse_dir;
  logic                     effect_on;

  logic            q_push, q_pop, q_full, q_empty;
  logic [4*IW-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_x    <= '0;
      mass_y    <= '0;
      drag_x    <= '0;
      drag_y    <= '0;
      max_force <= MAXF_RESET;
      pulse_dir <= '0;
      effect_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MASS_X:    mass_x    <= cfg_data[COEF_W-1:0];
        REG_MASS_Y:    mass_y    <= cfg_data[COEF_W-1:0];
        REG_DRAG_X:    drag_x    <= cfg_data[COEF_W-1:0];
        REG_DRAG_Y:    drag_y    <= cfg_data[COEF_W-1:0];
        REG_MAX_FORCE: max_force <= cfg_data[MAXF_W-1:0];
        REG_PULSE_DIR: pulse_dir <= cfg_data[DIR_W-1:0];
        REG_EFFECT_ON: effect_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: products and scaling
  dmdf_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .vel_x(vel_x), .vel_y(vel_y),
    .mass_x(mass_x), .mass_y(mass_y), .drag_x(drag_x), .drag_y(drag_y),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  dmdf_queue #(.WIDTH(4*IW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wr_data(q_wdata), .pop(q_pop),
    .rd_data(q_rdata), .full(q_full), .empty(q_empty)
  );

  // back: limiter, drag, saturation, output word
  dmdf_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FORCE_WIDTH(FORCE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .max_force(max_force), .pulse_dir(pulse_dir), .effect_on(effect_on),
    .out_valid(out_valid), .out_stall(out_stall), .force_x(force_x), .force_y(force_y)
  );
endmodule

// ----- verif/directional_mass_damper_force_core_test.sv -----
// Self-checking testbench for the directional mass-damper force core.
`timescale 1ns / 1ps
module directional_mass_damper_force_core_test;
  import dmdf_pkg::*;

  localparam int SW = DEF_SAMPLE_W;
  localparam int FW = DEF_FORCE_W;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] accel_x = '0, accel_y = '0, vel_x = '0, vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FW-1:0] force_x, force_y;

  directional_mass_damper_force_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file.
  logic signed [COEF_W-1:0] sh_mass_x, sh_mass_y, sh_drag_x, sh_drag_y;
  logic [MAXF_W-1:0] sh_max_force;
  logic [DIR_W-1:0] sh_pulse_dir;
  logic sh_effect_on;

  typedef struct packed {
    logic signed [FW-1:0] fx;
    logic signed [FW-1:0] fy;
  } force_word_t;

  force_word_t forces_due[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit hold_go = 1'b0;
  bit long_hold = 1'b0;

  // -coef*sample >> 8, rounding toward minus infinity (arithmetic shift does that).
  function automatic longint scaled_neg(longint s, longint c);
    longint p;
    p = -(s * c);
    return p >>> FRAC_SHIFT;
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_force(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (FW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic force_word_t damper_force(logic signed [SW-1:0] ax, logic signed [SW-1:0] ay,
                                               logic signed [SW-1:0] vx, logic signed [SW-1:0] vy);
    longint ix, iy, dx, dy, fx, fy, lim;
    longint unsigned mx, my, len, qx, qy;
    bit over;
    force_word_t w;
    fx = 0;
    fy = 0;
    lim = longint'(sh_max_force);
    if (sh_effect_on) begin
      ix = scaled_neg(ax, sh_mass_x);
      iy = scaled_neg(ay, sh_mass_y);
      dx = scaled_neg(vx, sh_drag_x);
      dy = scaled_neg(vy, sh_drag_y);
      mx = ix < 0 ? -ix : ix;
      my = iy < 0 ? -iy : iy;
      if (mx > lim || my > lim) over = 1'b1;
      else over = (mx * mx + my * my) > lim * lim;
      if (over) begin
        while (mx >= (64'd1 << 31) || my >= (64'd1 << 31)) begin
          mx = mx >> 1;
          my = my >> 1;
        end
        len = floor_root(mx * mx + my * my);
        if (len == 0) begin
          qx = 0;
          qy = 0;
        end else begin
          qx = mx * lim / len;
          qy = my * lim / len;
        end
        ix = ix < 0 ? -longint'(qx) : longint'(qx);
        iy = iy < 0 ? -longint'(qy) : longint'(qy);
      end
      fx = clamp_force(ix + dx);
      fy = clamp_force(iy + dy);
      // perturbation gate on x only, applied after saturation
      if (sh_pulse_dir == DIR_POS && fx < 0) fx = 0;
      else if (sh_pulse_dir == DIR_NEG && fx > 0) fx = 0;
    end
    w.fx = fx[FW-1:0];
    w.fy = fy[FW-1:0];
    return w;
  endfunction

  // Register write; the shadow is updated on the accepting edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MASS_X:    sh_mass_x = val[COEF_W-1:0];
      REG_MASS_Y:    sh_mass_y = val[COEF_W-1:0];
      REG_DRAG_X:    sh_drag_x = val[COEF_W-1:0];
      REG_DRAG_Y:    sh_drag_y = val[COEF_W-1:0];
      REG_MAX_FORCE: sh_max_force = val[MAXF_W-1:0];
      REG_PULSE_DIR: sh_pulse_dir = val[DIR_W-1:0];
      REG_EFFECT_ON: sh_effect_on = val[0];
      default: ;
    endcase
  endtask

  // Drop the input, drain, then let the longest rescale pass before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (forces_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] m_x, logic [15:0] m_y, logic [15:0] d_x,
                           logic [15:0] d_y, logic [22:0] lim, logic [1:0] dir, logic on);
    settle();
    write_reg(REG_MASS_X, {16'd0, m_x});
    write_reg(REG_MASS_Y, {16'd0, m_y});
    write_reg(REG_DRAG_X, {16'd0, d_x});
    write_reg(REG_DRAG_Y, {16'd0, d_y});
    write_reg(REG_MAX_FORCE, {9'd0, lim});
    write_reg(REG_PULSE_DIR, {30'd0, dir});
    write_reg(REG_EFFECT_ON, {31'd0, on});
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample word; the expectation is queued when it is taken.
  // When has_exp is set the hand-written expectation is checked against the predictor too.
  task automatic send_sample(logic signed [SW-1:0] ax, logic signed [SW-1:0] ay,
                             logic signed [SW-1:0] vx, logic signed [SW-1:0] vy,
                             bit has_exp, force_word_t exp_w);
    int gap;
    force_word_t w;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    vel_x <= vx;
    vel_y <= vy;
    do @(posedge clk); while (in_stall);
    w = damper_force(ax, ay, vx, vy);
    if (has_exp && w != exp_w) begin
      $display("%0t: table row disagrees: expected %h %h, predicted %h %h",
               $time, exp_w.fx, exp_w.fy, w.fx, w.fy);
      errors++;
    end
    forces_due.push_back(has_exp ? exp_w : w);
  endtask

  function automatic logic signed [SW-1:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($urandom_range(0, 63) - 32);
      default: return SW'($urandom());
    endcase
  endfunction

  // Output side: a drawn wait after each taken word, plus one long hold-off.
  always @(posedge clk) begin
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (rst || long_hold) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else if (out_valid && !out_stall && w > 0) begin
      out_stall <= 1'b1;
      rx_wait <= w - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int k;
    wait (hold_go);
    long_hold = 1'b1;
    k = 0;
    while (k < 600) begin
      @(posedge clk);
      k++;
    end
    long_hold = 1'b0;
  end

  // Checker: compare each accepted force word with the oldest expectation.
  always @(posedge clk) begin
    force_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (forces_due.size() == 0) begin
        $display("%0t: unexpected force word %h %h", $time, force_x, force_y);
        errors++;
      end else begin
        exp_w = forces_due.pop_front();
        if (force_x !== exp_w.fx) begin
          $display("%0t: force_x expected %h actual %h", $time, exp_w.fx, force_x);
          errors++;
        end
        if (force_y !== exp_w.fy) begin
          $display("%0t: force_y expected %h actual %h", $time, exp_w.fy, force_y);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  typedef struct {
    logic signed [SW-1:0] ax, ay, vx, vy;
    bit has_exp;
    force_word_t exp_w;
  } stim_row_t;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  stim_row_t zero_rows[] = '{
    '{0, 0, 0, 0, 1, '{0, 0}},
    '{SMAX, SMIN, SMAX, SMIN, 1, '{0, 0}},
    '{-1, -1, -1, -1, 1, '{0, 0}}
  };
  stim_row_t mix_rows[] = '{
    '{0, 0, 0, 0, 0, '{0, 0}},
    '{SMAX, SMAX, SMAX, SMAX, 0, '{0, 0}},
    '{SMIN, SMIN, SMIN, SMIN, 0, '{0, 0}},
    '{SMAX, SMIN, SMIN, SMAX, 0, '{0, 0}},
    '{1024, -1024, 512, -512, 0, '{0, 0}},
    '{-1, 1, -1, 1, 0, '{0, 0}},
    '{3000, 4000, 0, 0, 0, '{0, 0}},
    '{-3000, 4000, 100, -100, 0, '{0, 0}}
  };

  initial begin
    int n;
    sh_mass_x = 0; sh_mass_y = 0; sh_drag_x = 0; sh_drag_y = 0;
    sh_max_force = MAXF_RESET;
    sh_pulse_dir = '0;
    sh_effect_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset all coefficients are zero: force is zero whatever the sample.
    foreach (zero_rows[i])
      send_sample(zero_rows[i].ax, zero_rows[i].ay, zero_rows[i].vx, zero_rows[i].vy,
                  zero_rows[i].has_exp, zero_rows[i].exp_w);

    // Extreme coefficients, largest limit, then tight limit, zero limit, each pulse direction.
    write_all(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 23'h7fffff, 2'd0, 1'b1);
    foreach (mix_rows[i])
      send_sample(mix_rows[i].ax, mix_rows[i].ay, mix_rows[i].vx, mix_rows[i].vy, 0, '{0, 0});
    write_all(16'h0100, 16'h0100, 16'h0000, 16'h0000, 23'd5000, 2'd1, 1'b1);
    foreach (mix_rows[i])
      send_sample(mix_rows[i].ax, mix_rows[i].ay, mix_rows[i].vx, mix_rows[i].vy, 0, '{0, 0});
    // max_force 0 and no drag: any inertial force collapses to zero.
    write_all(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 23'd0, 2'd2, 1'b1);
    send_sample(SMAX, SMIN, 5, 5, 1, '{0, 0});
    send_sample(1000, -7, 0, 0, 1, '{0, 0});
    // Effect off: zero out, and the unused pulse code acts as none.
    write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 23'h7fffff, 2'd3, 1'b0);
    send_sample(SMAX, SMAX, SMAX, SMAX, 1, '{0, 0});
    send_sample(SMIN, SMIN, SMIN, SMIN, 1, '{0, 0});

    // Random part in phases with fresh settings; the long hold-off starts with the first.
    for (int ph = 0; ph < 9; ph++) begin
      write_all(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                23'(($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 1 << 16)),
                2'($urandom_range(0, 3)), ($urandom_range(0, 5) != 0));
      if (ph == 0) hold_go = 1'b1;
      for (n = 0; n < N_RANDOM / 9; n++)
        send_sample(rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(), 0, '{0, 0});
    end

    settle();
    if (errors == 0 && forces_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- directional_mass_damper_force_core.f -----
hdl/dmdf_pkg.sv
hdl/dmdf_front.sv
hdl/dmdf_queue.sv
hdl/dmdf_back.sv
hdl/directional_mass_damper_force_core.sv
verif/directional_mass_damper_force_core_test.sv
